// ===== hw/rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: text console writer definitions
// Screen geometry, cell constants and operation codes shared by the
// channel interfaces and the console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;

  // Internal widths follow the geometry.
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ROW_W  = $clog2(ROWS);

  // Field widths fixed by the channel payload.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned ATTR_W   = 8;
  localparam int unsigned CELL_A_W = 11;
  localparam int unsigned CURSOR_W = 11;
  localparam int unsigned CELL_W   = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F00;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

endpackage

// ===== hw/rtl/tcw_in_if.sv =====
// ----------------------------------------------------------------------------
// tcw_in_if: console command channel
// Valid/ready channel that carries one console operation per transaction.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  logic                              valid;
  logic                              ready;
  logic [tcw_pkg::OP_W-1:0]          operation;
  logic [tcw_pkg::CHAR_W-1:0]        character;
  logic [tcw_pkg::ATTR_W-1:0]        attribute;
  logic [tcw_pkg::CELL_A_W-1:0]      cell_address;

  modport source (output valid, output operation, output character,
                  output attribute, output cell_address, input ready);
  modport sink   (input valid, input operation, input character,
                  input attribute, input cell_address, output ready);
endinterface

// ===== hw/rtl/tcw_out_if.sv =====
// ----------------------------------------------------------------------------
// tcw_out_if: console result channel
// Valid/ready channel that carries the cursor and read data of one command.
// ----------------------------------------------------------------------------
interface tcw_out_if;
  logic                              valid;
  logic                              ready;
  logic [tcw_pkg::CURSOR_W-1:0]      cursor_position;
  logic [tcw_pkg::CELL_W-1:0]        read_data;

  modport source (output valid, output cursor_position, output read_data,
                  input ready);
  modport sink   (input valid, input cursor_position, input read_data,
                  output ready);
endinterface

// ===== hw/rtl/text_console_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_unit: text-mode console engine
// Holds the screen store and the cursor; puts characters, scrolls, clears
// and reads cells under a small sequencer around one single-port-pair RAM.
// ----------------------------------------------------------------------------
// Plain puts, newlines without scroll and undefined operations need no
// sequencer pass: the result is registered at the accepting edge. A cell
// read waits in ST_RDWAIT because the RAM read data is registered. A scroll
// copies rows 1 onward up a row (one RAM read and one write per cell), then
// blanks the bottom row. After reset a clearing pass writes the blank cell
// to all CELLS entries, one per cycle; no command is accepted until it ends.

module text_console_writer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcw_in_if.sink      in_i,
  tcw_out_if.source   out_o
);

  localparam int unsigned AW = tcw_pkg::ADDR_W;

  typedef enum logic [2:0] {
    ST_BLANK,
    ST_IDLE,
    ST_RDWAIT,
    ST_COPY,
    ST_FILL
  } state_e;

  state_e                         state_q;
  logic [AW-1:0]                  cursor_q;
  logic [tcw_pkg::COL_W-1:0]      col_q;
  logic [tcw_pkg::ROW_W-1:0]      row_q;
  logic [AW-1:0]                  idx_q;
  logic [AW-1:0]                  wa_q;
  logic                           pend_q;
  logic                           init_q;
  logic                           rd_ok_q;
  logic                           out_valid_q;
  logic [tcw_pkg::CURSOR_W-1:0]   out_cursor_q;
  logic [tcw_pkg::CELL_W-1:0]     out_data_q;

  logic [tcw_pkg::CELL_W-1:0]     mem [tcw_pkg::CELLS];
  logic [tcw_pkg::CELL_W-1:0]     rdata_q;

  logic                           in_ready;
  logic                           in_acc;
  logic                           addr_ok;
  logic                           last_cell;
  logic                           last_idx;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [tcw_pkg::CELL_W-1:0]     mem_wdata;
  logic                           mem_re;
  logic [AW-1:0]                  mem_raddr;

  assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_acc    = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  assign out_o.valid           = out_valid_q;
  assign out_o.cursor_position = out_cursor_q;
  assign out_o.read_data       = out_data_q;

  assign addr_ok   = 32'(in_i.cell_address) < tcw_pkg::CELLS;
  assign last_cell = cursor_q == AW'(tcw_pkg::CELLS - 1);
  assign last_idx  = idx_q == AW'(tcw_pkg::CELLS - 1);

  // Single write port: character puts, scroll copies and blank fills.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = tcw_pkg::BLANK_CELL;
    case (state_q)
      ST_IDLE: begin
        mem_we    = in_acc && (in_i.operation == tcw_pkg::OP_PUT) &&
                    (in_i.character != tcw_pkg::NEWLINE_CODE);
        mem_waddr = cursor_q;
        mem_wdata = {in_i.attribute, in_i.character};
      end
      ST_BLANK: begin
        mem_we = 1'b1;
      end
      ST_COPY: begin
        mem_we    = pend_q;
        mem_waddr = wa_q;
        mem_wdata = rdata_q;
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (pend_q) begin
          mem_waddr = wa_q;
          mem_wdata = rdata_q;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx_q;
    case (state_q)
      ST_IDLE: begin
        mem_re    = in_acc && (in_i.operation == tcw_pkg::OP_READ) && addr_ok;
        mem_raddr = AW'(in_i.cell_address);
      end
      ST_COPY: begin
        mem_re = 1'b1;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_BLANK;
      cursor_q     <= '0;
      col_q        <= '0;
      row_q        <= '0;
      idx_q        <= '0;
      wa_q         <= '0;
      pend_q       <= 1'b0;
      init_q       <= 1'b1;
      rd_ok_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_cursor_q <= '0;
      out_data_q   <= '0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_i.operation)
              tcw_pkg::OP_PUT: begin
                if (in_i.character == tcw_pkg::NEWLINE_CODE) begin
                  if (row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
                    state_q <= ST_COPY;
                    idx_q   <= AW'(tcw_pkg::COLUMNS);
                    pend_q  <= 1'b0;
                  end else begin
                    cursor_q     <= cursor_q - AW'(col_q) + AW'(tcw_pkg::COLUMNS);
                    col_q        <= '0;
                    row_q        <= row_q + 1'b1;
                    out_valid_q  <= 1'b1;
                    out_cursor_q <= tcw_pkg::CURSOR_W'(cursor_q - AW'(col_q) +
                                                       AW'(tcw_pkg::COLUMNS));
                    out_data_q   <= '0;
                  end
                end else if (last_cell) begin
                  // The character lands first, then the screen scrolls.
                  state_q <= ST_COPY;
                  idx_q   <= AW'(tcw_pkg::COLUMNS);
                  pend_q  <= 1'b0;
                end else begin
                  cursor_q <= cursor_q + 1'b1;
                  if (col_q == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) begin
                    col_q <= '0;
                    row_q <= row_q + 1'b1;
                  end else begin
                    col_q <= col_q + 1'b1;
                  end
                  out_valid_q  <= 1'b1;
                  out_cursor_q <= tcw_pkg::CURSOR_W'(cursor_q + 1'b1);
                  out_data_q   <= '0;
                end
              end
              tcw_pkg::OP_CLEAR: begin
                state_q <= ST_BLANK;
                idx_q   <= '0;
                init_q  <= 1'b0;
              end
              tcw_pkg::OP_READ: begin
                state_q <= ST_RDWAIT;
                rd_ok_q <= addr_ok;
              end
              default: begin
                out_valid_q  <= 1'b1;
                out_cursor_q <= tcw_pkg::CURSOR_W'(cursor_q);
                out_data_q   <= '0;
              end
            endcase
          end
        end
        ST_RDWAIT: begin
          state_q      <= ST_IDLE;
          out_valid_q  <= 1'b1;
          out_cursor_q <= tcw_pkg::CURSOR_W'(cursor_q);
          out_data_q   <= rd_ok_q ? rdata_q : '0;
        end
        ST_BLANK: begin
          if (last_idx) begin
            state_q  <= ST_IDLE;
            cursor_q <= '0;
            col_q    <= '0;
            row_q    <= '0;
            // The pass after reset produces no result.
            if (!init_q) begin
              out_valid_q  <= 1'b1;
              out_cursor_q <= '0;
              out_data_q   <= '0;
            end
            init_q <= 1'b0;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_COPY: begin
          // Read row r+1 now; its data is written to row r on the next cycle.
          pend_q <= 1'b1;
          wa_q   <= idx_q - AW'(tcw_pkg::COLUMNS);
          if (last_idx) begin
            state_q <= ST_FILL;
            idx_q   <= AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_FILL: begin
          if (pend_q) begin
            pend_q <= 1'b0;
          end else if (last_idx) begin
            state_q      <= ST_IDLE;
            cursor_q     <= AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
            col_q        <= '0;
            row_q        <= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
            out_valid_q  <= 1'b1;
            out_cursor_q <= tcw_pkg::CURSOR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
            out_data_q   <= '0;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // The cursor never leaves the screen.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cursor_q) < tcw_pkg::CELLS)
    else $error("cursor outside the screen");

  // Row and column always describe the same cell as the cursor.
  a_cursor_rowcol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cursor_q) == 32'(row_q) * tcw_pkg::COLUMNS + 32'(col_q))
    else $error("cursor disagrees with row and column");

  // A read in flight never overlaps a RAM write.
  a_read_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RDWAIT) |-> !mem_we)
    else $error("RAM written while a read is in flight");

  // A clear transaction blocks the command channel on the next cycle.
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.operation == tcw_pkg::OP_CLEAR)) |=> !in_ready)
    else $error("command accepted during a clear");

endmodule

// ===== verif/text_console_writer_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_unit_test: self-checking bench for the console writer
// Sends put, clear, read and undefined commands over the command channel and
// checks every result transaction against a shadow copy of the screen and
// cursor. A short table covers reset contents, field extremes and the odd
// cases. Random episodes follow: text runs, reads, clears, noise and full
// walks to the bottom of the screen that force both kinds of scroll. Both
// channels pause in random bursts until the last stretch of the run.
// ----------------------------------------------------------------------------

module text_console_writer_unit_test;

  localparam logic [tcw_pkg::OP_W-1:0] OP_UNDEFINED = 2'd3;

  localparam int unsigned RANDOM_ITEMS  = 300;
  localparam int unsigned TAIL_ITEMS    = 40;
  localparam int unsigned SCROLL_CYCLES = tcw_pkg::CELLS + 2;
  // About 450 commands at worst, each a scroll with full stalls on both
  // sides, plus the clearing pass after reset; taken four times over.
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int unsigned DIRECTED_ROWS = 22;

  typedef struct packed {
    logic [tcw_pkg::OP_W-1:0]     op;
    logic [tcw_pkg::CHAR_W-1:0]   ch;
    logic [tcw_pkg::ATTR_W-1:0]   attr;
    logic [tcw_pkg::CELL_A_W-1:0] addr;
  } console_cmd_t;

  typedef struct packed {
    logic [tcw_pkg::CURSOR_W-1:0] cursor;
    logic [tcw_pkg::CELL_W-1:0]   data;
  } console_view_t;

  typedef struct packed {
    logic [tcw_pkg::OP_W-1:0]     op;
    logic [tcw_pkg::CHAR_W-1:0]   ch;
    logic [tcw_pkg::ATTR_W-1:0]   attr;
    logic [tcw_pkg::CELL_A_W-1:0] addr;
    logic                         fixed;
    logic [tcw_pkg::CURSOR_W-1:0] cursor;
    logic [tcw_pkg::CELL_W-1:0]   data;
  } directed_row_t;

  // Rows marked fixed carry the result that must come back; the others are
  // checked against the shadow screen.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{tcw_pkg::OP_READ,  8'h00, 8'h00, 11'd0,    1'b1, 11'd0, tcw_pkg::BLANK_CELL},
    '{tcw_pkg::OP_READ,  8'hFF, 8'hFF, 11'd1999, 1'b1, 11'd0, tcw_pkg::BLANK_CELL},
    '{tcw_pkg::OP_READ,  8'h00, 8'h00, 11'd2000, 1'b1, 11'd0, 16'h0000},
    '{tcw_pkg::OP_READ,  8'hFF, 8'hFF, 11'd2047, 1'b1, 11'd0, 16'h0000},
    '{OP_UNDEFINED,      8'hFF, 8'hFF, 11'd2047, 1'b1, 11'd0, 16'h0000},
    '{tcw_pkg::OP_PUT,   8'h41, 8'h07, 11'd2047, 1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::OP_PUT,   8'h00, 8'h00, 11'd0,    1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::OP_PUT,   8'hFF, 8'hFF, 11'd1024, 1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::OP_PUT,   8'h0B, 8'h80, 11'd0,    1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::OP_PUT,   8'h09, 8'h01, 11'd1999, 1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::OP_READ,  8'h41, 8'h07, 11'd0,    1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::OP_READ,  8'h00, 8'h00, 11'd2,    1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::OP_PUT,   tcw_pkg::NEWLINE_CODE, 8'hAA, 11'd5, 1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::OP_PUT,   8'h5A, 8'h1F, 11'd0,    1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::OP_READ,  8'h00, 8'h00, 11'd80,   1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::OP_READ,  8'hFF, 8'h00, 11'd81,   1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::OP_CLEAR, 8'h41, 8'h07, 11'd5,    1'b1, 11'd0, 16'h0000},
    '{tcw_pkg::OP_READ,  8'h00, 8'h00, 11'd0,    1'b1, 11'd0, tcw_pkg::BLANK_CELL},
    '{tcw_pkg::OP_READ,  8'h00, 8'h00, 11'd80,   1'b1, 11'd0, tcw_pkg::BLANK_CELL},
    '{OP_UNDEFINED,      8'h00, 8'h00, 11'd0,    1'b1, 11'd0, 16'h0000},
    '{tcw_pkg::OP_PUT,   tcw_pkg::NEWLINE_CODE, 8'h00, 11'd0, 1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::OP_PUT,   tcw_pkg::NEWLINE_CODE, 8'hFF, 11'd7, 1'b0, 11'd0, 16'h0000}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  tcw_in_if  cmd_if ();
  tcw_out_if res_if ();

  text_console_writer_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [tcw_pkg::CELL_W-1:0] shadow_cells [tcw_pkg::CELLS];
  int unsigned                shadow_cursor;
  console_view_t              pending_views [$];
  int unsigned                mismatch_count = 0;
  int unsigned                counted_items  = 0;
  int unsigned                stall_cycles   = 0;
  int unsigned                cycle_count    = 0;
  logic                       steady_flow    = 1'b0;

  function automatic void blank_shadow();
    for (int i = 0; i < tcw_pkg::CELLS; i++) shadow_cells[i] = tcw_pkg::BLANK_CELL;
    shadow_cursor = 0;
  endfunction

  function automatic void scroll_shadow();
    for (int i = 0; i + tcw_pkg::COLUMNS < tcw_pkg::CELLS; i++) begin
      shadow_cells[i] = shadow_cells[i + tcw_pkg::COLUMNS];
    end
    for (int i = tcw_pkg::CELLS - tcw_pkg::COLUMNS; i < tcw_pkg::CELLS; i++) begin
      shadow_cells[i] = tcw_pkg::BLANK_CELL;
    end
    shadow_cursor = tcw_pkg::CELLS - tcw_pkg::COLUMNS;
  endfunction

  function automatic console_view_t apply_console_command(console_cmd_t c);
    console_view_t v;
    v.data = '0;
    if (shadow_cursor >= tcw_pkg::CELLS) shadow_cursor = 0;
    case (c.op)
      tcw_pkg::OP_PUT: begin
        if (c.ch == tcw_pkg::NEWLINE_CODE) begin
          if (shadow_cursor / tcw_pkg::COLUMNS == tcw_pkg::ROWS - 1) scroll_shadow();
          else shadow_cursor = (shadow_cursor / tcw_pkg::COLUMNS + 1) * tcw_pkg::COLUMNS;
        end else begin
          // The character lands before the scroll, so it moves up a row.
          shadow_cells[shadow_cursor] = {c.attr, c.ch};
          if (shadow_cursor == tcw_pkg::CELLS - 1) scroll_shadow();
          else shadow_cursor++;
        end
      end
      tcw_pkg::OP_CLEAR: blank_shadow();
      tcw_pkg::OP_READ: begin
        if (c.addr < tcw_pkg::CELLS) v.data = shadow_cells[c.addr];
      end
      default: ;
    endcase
    v.cursor = tcw_pkg::CURSOR_W'(shadow_cursor);
    return v;
  endfunction

  function automatic console_cmd_t random_cmd(logic [tcw_pkg::OP_W-1:0] op);
    console_cmd_t c;
    logic [31:0]  r;
    r      = $urandom();
    c.op   = op;
    c.ch   = r[7:0];
    c.attr = r[15:8];
    c.addr = r[26:16];
    return c;
  endfunction

  task automatic send_console_command(input console_cmd_t c, input logic fixed,
                                      input console_view_t fixed_view);
    console_view_t predicted;
    if (!steady_flow && $urandom_range(0, 5) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.operation    <= c.op;
    cmd_if.character    <= c.ch;
    cmd_if.attribute    <= c.attr;
    cmd_if.cell_address <= c.addr;
    do @(posedge clk_i); while (!cmd_if.ready);
    predicted = apply_console_command(c);
    pending_views.push_back(fixed ? fixed_view : predicted);
    counted_items++;
  endtask

  task automatic hold_until_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_views.size() != 0);
  endtask

  always @(posedge clk_i) begin : result_check
    console_view_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_views.size() == 0) begin
        $error("result transaction with nothing expected: cursor_position %0d read_data %h",
               res_if.cursor_position, res_if.read_data);
        mismatch_count++;
      end else begin
        want = pending_views.pop_front();
        if (res_if.cursor_position !== want.cursor) begin
          $error("cursor_position: expected %0d, actual %0d", want.cursor,
                 res_if.cursor_position);
          mismatch_count++;
        end
        if (res_if.read_data !== want.data) begin
          $error("read_data: expected %h, actual %h", want.data, res_if.read_data);
          mismatch_count++;
        end
      end
    end
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (steady_flow) begin
      res_if.ready <= 1'b1;
    end else if (stall_cycles > 0) begin
      stall_cycles--;
      res_if.ready <= 1'b0;
    end else if ($urandom_range(0, 6) == 0) begin
      stall_cycles = $urandom_range(0, 4);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_console_writer_unit_test: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    console_cmd_t cmd;
    int unsigned  kind;
    int unsigned  episode_count;
    rst_ni              <= 1'b0;
    cmd_if.valid        <= 1'b0;
    cmd_if.operation    <= tcw_pkg::OP_PUT;
    cmd_if.character    <= '0;
    cmd_if.attribute    <= '0;
    cmd_if.cell_address <= '0;
    blank_shadow();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      cmd = console_cmd_t'{directed_rows[i].op, directed_rows[i].ch,
                           directed_rows[i].attr, directed_rows[i].addr};
      send_console_command(cmd, directed_rows[i].fixed,
                           console_view_t'{directed_rows[i].cursor, directed_rows[i].data});
    end
    hold_until_drained();

    counted_items = 0;
    episode_count = 0;
    while (counted_items < RANDOM_ITEMS) begin
      steady_flow = (counted_items + TAIL_ITEMS >= RANDOM_ITEMS) || ($urandom_range(0, 3) == 0);
      // The first episode always walks to the bottom so both scrolls occur early.
      kind = (episode_count == 0) ? 19 : $urandom_range(0, 19);
      episode_count++;
      if (kind <= 9) begin
        repeat ($urandom_range(5, 60)) begin
          cmd = random_cmd(tcw_pkg::OP_PUT);
          if ($urandom_range(0, 9) == 0) cmd.ch = tcw_pkg::NEWLINE_CODE;
          send_console_command(cmd, 1'b0, '0);
        end
      end else if (kind <= 13) begin
        repeat ($urandom_range(1, 8)) begin
          cmd = random_cmd(tcw_pkg::OP_READ);
          case ($urandom_range(0, 5))
            0: cmd.addr = tcw_pkg::CELL_A_W'($urandom_range(tcw_pkg::CELLS,
                                                            2 ** tcw_pkg::CELL_A_W - 1));
            1, 2: cmd.addr = tcw_pkg::CELL_A_W'(shadow_cursor -
                     $urandom_range(0, shadow_cursor < tcw_pkg::COLUMNS ?
                                       shadow_cursor : tcw_pkg::COLUMNS));
            default: cmd.addr = tcw_pkg::CELL_A_W'($urandom_range(0, tcw_pkg::CELLS - 1));
          endcase
          send_console_command(cmd, 1'b0, '0);
        end
      end else if (kind <= 15) begin
        repeat ($urandom_range(1, 4)) send_console_command(random_cmd(OP_UNDEFINED), 1'b0, '0);
      end else if (kind == 16) begin
        send_console_command(random_cmd(tcw_pkg::OP_CLEAR), 1'b0, '0);
      end else if (kind == 17) begin
        hold_until_drained();
      end else begin
        cmd = random_cmd(tcw_pkg::OP_PUT);
        cmd.ch = tcw_pkg::NEWLINE_CODE;
        while (shadow_cursor / tcw_pkg::COLUMNS != tcw_pkg::ROWS - 1) begin
          send_console_command(cmd, 1'b0, '0);
        end
        // A newline on the bottom row scrolls the screen.
        send_console_command(cmd, 1'b0, '0);
        // Fill the bottom row; the put at the last cell scrolls again.
        do begin
          cmd = random_cmd(tcw_pkg::OP_PUT);
          if (cmd.ch == tcw_pkg::NEWLINE_CODE) cmd.ch = ~tcw_pkg::NEWLINE_CODE;
          send_console_command(cmd, 1'b0, '0);
        end while (shadow_cursor != tcw_pkg::CELLS - tcw_pkg::COLUMNS);
        repeat (4) begin
          cmd = random_cmd(tcw_pkg::OP_READ);
          cmd.addr = tcw_pkg::CELL_A_W'((tcw_pkg::ROWS - 2) * tcw_pkg::COLUMNS +
                                        $urandom_range(0, 2 * tcw_pkg::COLUMNS - 1));
          send_console_command(cmd, 1'b0, '0);
        end
      end
    end

    steady_flow = 1'b1;
    hold_until_drained();
    repeat (SCROLL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("text_console_writer_unit_test: PASS");
    end else begin
      $display("text_console_writer_unit_test: FAIL");
    end
    $finish;
  end

endmodule
